>>> src/fabs_pkg.sv
package fabs_pkg;

   // widths of the timing registers and the counters
   localparam int unsigned MS_W    = 12;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned CODE_W  = 8;

   // register file layout
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_ON_MS       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_OFF_MS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_PAUSE_MS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEADY_HALF_MS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIBLE_CYCLES   = 3'd4;

   // register reset values
   localparam logic [MS_W-1:0]    RST_BEEP_ON_MS       = 12'd200;
   localparam logic [MS_W-1:0]    RST_BEEP_OFF_MS      = 12'd200;
   localparam logic [MS_W-1:0]    RST_PATTERN_PAUSE_MS = 12'd1000;
   localparam logic [MS_W-1:0]    RST_STEADY_HALF_MS   = 12'd1500;
   localparam logic [COUNT_W-1:0] RST_AUDIBLE_CYCLES   = 3'd3;

   // upper nibble range that selects a beep pattern
   localparam logic [3:0] BEEP_NIBBLE_MIN = 4'h1;
   localparam logic [3:0] BEEP_NIBBLE_MAX = 4'h5;

   // request opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_FATAL = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_BEEP_ON  = 3'd1,
      PH_BEEP_OFF = 3'd2,
      PH_PAUSE    = 3'd3,
      PH_STEADY_A = 3'd4,
      PH_STEADY_B = 3'd5,
      PH_HALTED   = 3'd6
   } phase_type;

   typedef struct packed {
      logic              buzzer_on;
      logic              watchdog_kick;
      logic              alarm_active;
      logic              halted;
      logic [CODE_W-1:0] last_event;
   } result_type;

   // a duration of zero counts as one tick
   function automatic logic [MS_W-1:0] dur(input logic [MS_W-1:0] v);
      dur = (v == '0) ? MS_W'(1) : v;
   endfunction

endpackage

>>> src/fatal_alarm_beep_sequencer_top.sv
// Fatal-fault alarm sequencer. Each request is a 1 ms tick (opcode 0) or a
// fatal event (opcode 1) with an 8-bit code; every request yields exactly one
// response showing the state after it. A code whose upper nibble is 1..5
// plays that many beeps per cycle, any other code plays a two-half steady
// tone; after audible_cycles cycles the tone stays on with no more watchdog
// kicks. A second fatal event while active goes straight to halt. One request
// is taken every clock cycle while req_stall is low: the whole update is one
// compare-and-decrement of the period timer between request port and response
// register. A two-entry response buffer (output register plus skid register)
// keeps the request side open while one response waits. Timing registers are
// sampled when a period starts; write them only while the block is idle.
module fatal_alarm_beep_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [fabs_pkg::CODE_W-1:0]       req_event_code,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_buzzer_on,
   output logic                              rsp_watchdog_kick,
   output logic                              rsp_alarm_active,
   output logic                              rsp_halted,
   output logic [fabs_pkg::CODE_W-1:0]       rsp_last_event,
   // configuration port
   input  logic                              csr_wr_en,
   input  logic [fabs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fabs_pkg::MS_W-1:0]         csr_wdata
);

   // configuration registers
   logic [fabs_pkg::MS_W-1:0]    beep_on_ms_ff;
   logic [fabs_pkg::MS_W-1:0]    beep_off_ms_ff;
   logic [fabs_pkg::MS_W-1:0]    pattern_pause_ms_ff;
   logic [fabs_pkg::MS_W-1:0]    steady_half_ms_ff;
   logic [fabs_pkg::COUNT_W-1:0] audible_cycles_ff;

   // sequencer state
   fabs_pkg::phase_type          phase_ff, phase_in;
   logic [fabs_pkg::MS_W-1:0]    time_left_ff, time_left_in;
   logic [fabs_pkg::COUNT_W-1:0] beep_total_ff, beep_total_in;
   logic [fabs_pkg::COUNT_W-1:0] beep_index_ff, beep_index_in;
   logic [fabs_pkg::COUNT_W-1:0] cycle_count_ff, cycle_count_in;
   logic [fabs_pkg::CODE_W-1:0]  recorded_event_ff, recorded_event_in;

   // response buffer
   logic                 out_valid_ff, out_valid_in;
   fabs_pkg::result_type out_data_ff, out_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   fabs_pkg::result_type skid_data_ff, skid_data_in;

   // per-request decode
   logic                         accept;
   logic                         is_fatal;
   logic                         is_tick;
   logic                         running;
   logic [3:0]                   code_hi;
   logic                         beep_code;
   logic [fabs_pkg::MS_W-1:0]    time_dec;
   logic                         expire;
   logic [fabs_pkg::COUNT_W-1:0] beep_index_inc;
   logic [fabs_pkg::COUNT_W-1:0] cycle_count_inc;
   logic                         last_cycle;
   logic                         kick;
   fabs_pkg::result_type         result;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign is_fatal  = accept && (req_opcode == fabs_pkg::OP_FATAL);
   assign is_tick   = accept && (req_opcode == fabs_pkg::OP_TICK);
   assign running   = (phase_ff != fabs_pkg::PH_IDLE) && (phase_ff != fabs_pkg::PH_HALTED);

   assign code_hi   = req_event_code[fabs_pkg::CODE_W-1 -: 4];
   assign beep_code = (code_hi >= fabs_pkg::BEEP_NIBBLE_MIN) &&
                      (code_hi <= fabs_pkg::BEEP_NIBBLE_MAX);

   assign time_dec        = time_left_ff - fabs_pkg::MS_W'(1);
   assign expire          = is_tick && running && (time_dec == '0);
   assign beep_index_inc  = beep_index_ff + fabs_pkg::COUNT_W'(1);
   assign cycle_count_inc = cycle_count_ff + fabs_pkg::COUNT_W'(1);
   assign last_cycle      = cycle_count_inc >= audible_cycles_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         beep_on_ms_ff       <= fabs_pkg::RST_BEEP_ON_MS;
         beep_off_ms_ff      <= fabs_pkg::RST_BEEP_OFF_MS;
         pattern_pause_ms_ff <= fabs_pkg::RST_PATTERN_PAUSE_MS;
         steady_half_ms_ff   <= fabs_pkg::RST_STEADY_HALF_MS;
         audible_cycles_ff   <= fabs_pkg::RST_AUDIBLE_CYCLES;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fabs_pkg::CSR_BEEP_ON_MS:       beep_on_ms_ff       <= csr_wdata;
            fabs_pkg::CSR_BEEP_OFF_MS:      beep_off_ms_ff      <= csr_wdata;
            fabs_pkg::CSR_PATTERN_PAUSE_MS: pattern_pause_ms_ff <= csr_wdata;
            fabs_pkg::CSR_STEADY_HALF_MS:   steady_half_ms_ff   <= csr_wdata;
            fabs_pkg::CSR_AUDIBLE_CYCLES:
               audible_cycles_ff <= csr_wdata[fabs_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      phase_in          = phase_ff;
      time_left_in      = time_left_ff;
      beep_total_in     = beep_total_ff;
      beep_index_in     = beep_index_ff;
      cycle_count_in    = cycle_count_ff;
      recorded_event_in = recorded_event_ff;
      if (is_fatal) begin
         if (phase_ff == fabs_pkg::PH_IDLE) begin
            recorded_event_in = req_event_code;
            beep_total_in     = beep_code ? code_hi[fabs_pkg::COUNT_W-1:0] : '0;
            beep_index_in     = '0;
            cycle_count_in    = '0;
            if (beep_code) begin
               phase_in     = fabs_pkg::PH_BEEP_ON;
               time_left_in = fabs_pkg::dur(beep_on_ms_ff);
            end else begin
               phase_in     = fabs_pkg::PH_STEADY_A;
               time_left_in = fabs_pkg::dur(steady_half_ms_ff);
            end
         end else begin
            phase_in     = fabs_pkg::PH_HALTED;
            time_left_in = '0;
         end
      end else if (is_tick && running) begin
         time_left_in = time_dec;
         if (expire) begin
            unique case (phase_ff)
               fabs_pkg::PH_BEEP_ON: begin
                  phase_in     = fabs_pkg::PH_BEEP_OFF;
                  time_left_in = fabs_pkg::dur(beep_off_ms_ff);
               end
               fabs_pkg::PH_BEEP_OFF: begin
                  beep_index_in = beep_index_inc;
                  if (beep_index_inc < beep_total_ff) begin
                     phase_in     = fabs_pkg::PH_BEEP_ON;
                     time_left_in = fabs_pkg::dur(beep_on_ms_ff);
                  end else begin
                     phase_in     = fabs_pkg::PH_PAUSE;
                     time_left_in = fabs_pkg::dur(pattern_pause_ms_ff);
                  end
               end
               fabs_pkg::PH_STEADY_A: begin
                  phase_in     = fabs_pkg::PH_STEADY_B;
                  time_left_in = fabs_pkg::dur(steady_half_ms_ff);
               end
               fabs_pkg::PH_PAUSE, fabs_pkg::PH_STEADY_B: begin
                  cycle_count_in = cycle_count_inc;
                  if (last_cycle) begin
                     phase_in     = fabs_pkg::PH_HALTED;
                     time_left_in = '0;
                  end else if (phase_ff == fabs_pkg::PH_PAUSE) begin
                     beep_index_in = '0;
                     phase_in      = fabs_pkg::PH_BEEP_ON;
                     time_left_in  = fabs_pkg::dur(beep_on_ms_ff);
                  end else begin
                     phase_in     = fabs_pkg::PH_STEADY_A;
                     time_left_in = fabs_pkg::dur(steady_half_ms_ff);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // response fields
   always_comb begin
      kick = 1'b0;
      if (is_fatal) begin
         kick = (phase_ff == fabs_pkg::PH_IDLE);
      end else if (expire) begin
         unique case (phase_ff)
            fabs_pkg::PH_BEEP_OFF, fabs_pkg::PH_STEADY_A: kick = 1'b1;
            fabs_pkg::PH_PAUSE, fabs_pkg::PH_STEADY_B:    kick = !last_cycle;
            default:                                      kick = 1'b0;
         endcase
      end
      result.buzzer_on     = (phase_in == fabs_pkg::PH_BEEP_ON)  ||
                             (phase_in == fabs_pkg::PH_STEADY_A) ||
                             (phase_in == fabs_pkg::PH_STEADY_B) ||
                             (phase_in == fabs_pkg::PH_HALTED);
      result.watchdog_kick = kick;
      result.alarm_active  = (phase_in != fabs_pkg::PH_IDLE);
      result.halted        = (phase_in == fabs_pkg::PH_HALTED);
      result.last_event    = recorded_event_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= fabs_pkg::PH_IDLE;
         time_left_ff      <= '0;
         beep_total_ff     <= '0;
         beep_index_ff     <= '0;
         cycle_count_ff    <= '0;
         recorded_event_ff <= '0;
      end else begin
         phase_ff          <= phase_in;
         time_left_ff      <= time_left_in;
         beep_total_ff     <= beep_total_in;
         beep_index_ff     <= beep_index_in;
         cycle_count_ff    <= cycle_count_in;
         recorded_event_ff <= recorded_event_in;
      end
   end

   // response buffer: output register with a skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_stall) begin
         if (accept) begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = accept;
         out_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_buzzer_on     = out_data_ff.buzzer_on;
   assign rsp_watchdog_kick = out_data_ff.watchdog_kick;
   assign rsp_alarm_active  = out_data_ff.alarm_active;
   assign rsp_halted        = out_data_ff.halted;
   assign rsp_last_event    = out_data_ff.last_event;

endmodule
